// ===== hw/rtl/als_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// anti-aliased line stepper. No dependencies.
package als_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int CHAN_BITS   = 8;
    localparam int PIX_BITS    = COORD_BITS + 1;
    localparam int QUO_BITS    = COORD_BITS + FRAC_BITS;
    localparam int MINOR_BITS  = QUO_BITS + 1;
    localparam int ACC_BITS    = CHAN_BITS + FRAC_BITS + 1;
    localparam int DIFF_BITS   = CHAN_BITS + 1;
    localparam int CNT_BITS    = $clog2(QUO_BITS + 1);
    localparam int IN_BITS     = 4 * COORD_BITS + 6 * CHAN_BITS;
    localparam int OUT_BITS    = 64;
    localparam int SEL_BITS    = 2;

    // Request kinds carried in tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Division jobs run in this order after a load.
    localparam logic [SEL_BITS-1:0] DIV_MINOR = 2'd0;
    localparam logic [SEL_BITS-1:0] DIV_RED   = 2'd1;
    localparam logic [SEL_BITS-1:0] DIV_GREEN = 2'd2;
    localparam logic [SEL_BITS-1:0] DIV_BLUE  = 2'd3;

    typedef struct packed {
        logic                load;
        logic                div_start;
        logic                div_store;
        logic [SEL_BITS-1:0] div_sel;
        logic                advance;
        logic                pix_sel;
    } t_cmd;

    typedef struct packed {
        logic line_active;
        logic div_done;
        logic last_step;
    } t_status;

endpackage

// ===== hw/rtl/als_div.sv =====
// Restoring divider: (mag << FRAC_BITS) / den, one quotient bit per cycle.
// Depends on als_pkg.
module als_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [als_pkg::COORD_BITS-1:0]  i_mag,
    input  logic [als_pkg::COORD_BITS-1:0]  i_den,
    output logic                            o_done,
    output logic [als_pkg::QUO_BITS-1:0]    o_quo
);
    import als_pkg::*;

    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [COORD_BITS-1:0] r_rem, n_rem;
    logic [QUO_BITS-1:0]   r_quo, n_quo;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   shifted;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        shifted = {r_rem, r_quo[QUO_BITS-1]};
        trial   = shifted - {1'b0, i_den};
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(QUO_BITS);
            n_rem  = '0;
            n_quo  = {i_mag, {FRAC_BITS{1'b0}}};
        end else if (r_busy) begin
            if (shifted >= {1'b0, i_den}) begin
                n_rem = trial[COORD_BITS-1:0];
                n_quo = {r_quo[QUO_BITS-2:0], 1'b1};
            end else begin
                n_rem = shifted[COORD_BITS-1:0];
                n_quo = {r_quo[QUO_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/als_datapath.sv =====
// Line state, setup arithmetic, stepping adders and pixel formatting.
// Depends on als_pkg and als_div.
module als_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  als_pkg::t_cmd                  i_cmd,
    input  logic [als_pkg::IN_BITS-1:0]    i_data,
    output als_pkg::t_status               o_status,
    output logic [als_pkg::OUT_BITS-1:0]   o_data
);
    import als_pkg::*;

    logic                         r_line_active;
    logic                         r_steep;
    logic                         r_desc;
    logic [COORD_BITS-1:0]        r_major, r_limit;
    logic signed [MINOR_BITS-1:0] r_minor, r_minor_inc;
    logic signed [ACC_BITS-1:0]   r_acc   [3];
    logic signed [ACC_BITS-1:0]   r_delta [3];
    logic [COORD_BITS-1:0]        r_span;
    logic [COORD_BITS-1:0]        r_minor_mag;
    logic                         r_minor_neg;
    logic signed [DIFF_BITS-1:0]  r_diff  [3];

    logic [COORD_BITS-1:0] xs, ys, xe, ye, in_xs, in_ys, in_xe, in_ye;
    logic [CHAN_BITS-1:0]  cs [3];
    logic [CHAN_BITS-1:0]  ce [3];
    logic [CHAN_BITS-1:0]  in_cs [3];
    logic [CHAN_BITS-1:0]  in_ce [3];
    logic                  swap;
    logic [COORD_BITS-1:0] dx, ady;
    logic signed [COORD_BITS:0] dy;
    logic                  steep;

    logic [COORD_BITS-1:0] div_mag;
    logic                  div_neg;
    logic                  div_done;
    logic [QUO_BITS-1:0]   div_quo, quo;
    logic [DIFF_BITS-1:0]  diff_abs;

    // Unpack the load request.
    always_comb begin
        in_xs = i_data[COORD_BITS-1:0];
        in_ys = i_data[2*COORD_BITS-1:COORD_BITS];
        in_xe = i_data[3*COORD_BITS-1:2*COORD_BITS];
        in_ye = i_data[4*COORD_BITS-1:3*COORD_BITS];
        for (int k = 0; k < 3; k++) begin
            in_cs[k] = i_data[4*COORD_BITS + k*CHAN_BITS +: CHAN_BITS];
            in_ce[k] = i_data[4*COORD_BITS + (k+3)*CHAN_BITS +: CHAN_BITS];
        end
    end

    // Order endpoints by x and pick the major axis.
    always_comb begin
        swap = in_xe < in_xs;
        xs = swap ? in_xe : in_xs;
        xe = swap ? in_xs : in_xe;
        ys = swap ? in_ye : in_ys;
        ye = swap ? in_ys : in_ye;
        for (int k = 0; k < 3; k++) begin
            cs[k] = swap ? in_ce[k] : in_cs[k];
            ce[k] = swap ? in_cs[k] : in_ce[k];
        end
        dx    = xe - xs;
        dy    = $signed({1'b0, ye}) - $signed({1'b0, ys});
        ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        steep = (dx == '0) || (ady >= dx);
    end

    // Operand selection for the shared divider.
    always_comb begin
        if (i_cmd.div_sel == DIV_MINOR) begin
            div_mag  = r_minor_mag;
            div_neg  = r_minor_neg;
            diff_abs = '0;
        end else begin
            diff_abs = r_diff[i_cmd.div_sel - 1'b1][DIFF_BITS-1]
                     ? DIFF_BITS'(-r_diff[i_cmd.div_sel - 1'b1])
                     : r_diff[i_cmd.div_sel - 1'b1];
            div_mag  = COORD_BITS'(diff_abs);
            div_neg  = r_diff[i_cmd.div_sel - 1'b1][DIFF_BITS-1];
        end
        quo = (r_span == '0) ? '0 : div_quo;
    end

    als_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (div_mag),
        .i_den   (r_span),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Line active flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_line_active <= 1'b1;
        end else if (i_cmd.advance && (r_major == r_limit)) begin
            r_line_active <= 1'b0;
        end
    end

    // Setup, division results and stepping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steep <= steep;
            for (int k = 0; k < 3; k++) begin
                r_acc[k]  <= ACC_BITS'({cs[k], {FRAC_BITS{1'b0}}});
                r_diff[k] <= $signed({1'b0, ce[k]}) - $signed({1'b0, cs[k]});
            end
            if (steep) begin
                r_desc      <= dy[COORD_BITS];
                r_major     <= ys;
                r_limit     <= ye;
                r_minor     <= MINOR_BITS'({xs, {FRAC_BITS{1'b0}}});
                r_minor_mag <= dx;
                r_minor_neg <= 1'b0;
                r_span      <= ady;
            end else begin
                r_desc      <= 1'b0;
                r_major     <= xs;
                r_limit     <= xe;
                r_minor     <= MINOR_BITS'({ys, {FRAC_BITS{1'b0}}});
                r_minor_mag <= ady;
                r_minor_neg <= dy[COORD_BITS];
                r_span      <= dx;
            end
        end else if (i_cmd.advance && (r_major != r_limit)) begin
            r_major <= r_desc ? r_major - 1'b1 : r_major + 1'b1;
            r_minor <= r_minor + r_minor_inc;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= r_acc[k] + r_delta[k];
            end
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel == DIV_MINOR) begin
                r_minor_inc <= div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
            end else begin
                r_delta[i_cmd.div_sel - 1'b1] <= div_neg
                    ? -$signed({1'b0, quo[ACC_BITS-2:0]})
                    : $signed({1'b0, quo[ACC_BITS-2:0]});
            end
        end
    end

    // Pixel formatting.
    logic [FRAC_BITS-1:0]         frac;
    logic [PIX_BITS-1:0]          fl_lo, fl_hi, minor_pix, major_pix;
    logic [FRAC_BITS+CHAN_BITS-1:0] cov_prod;
    logic [CHAN_BITS-1:0]         cov, chan [3];
    logic [PIX_BITS-1:0]          px, py;

    always_comb begin
        frac      = r_minor[FRAC_BITS-1:0];
        fl_lo     = r_minor[FRAC_BITS +: PIX_BITS];
        fl_hi     = fl_lo + 1'b1;
        minor_pix = i_cmd.pix_sel ? fl_lo : fl_hi;
        major_pix = {1'b0, r_major};
        cov_prod  = {frac, {CHAN_BITS{1'b0}}} - {{CHAN_BITS{1'b0}}, frac};
        cov       = cov_prod[FRAC_BITS +: CHAN_BITS];
        if (i_cmd.pix_sel) begin
            cov = {CHAN_BITS{1'b1}} - cov;
        end
        for (int k = 0; k < 3; k++) begin
            if (r_acc[k][ACC_BITS-1]) begin
                chan[k] = '0;
            end else begin
                chan[k] = r_acc[k][FRAC_BITS +: CHAN_BITS];
            end
        end
        px = r_steep ? minor_pix : major_pix;
        py = r_steep ? major_pix : minor_pix;
        o_data = OUT_BITS'({cov, chan[2], chan[1], chan[0], py, px});
    end

    assign o_status.line_active = r_line_active;
    assign o_status.div_done    = div_done;
    assign o_status.last_step   = (r_major == r_limit);

endmodule

// ===== hw/rtl/als_ctrl.sv =====
// Controller state machine: handshakes, setup division sequencing, pair output.
// Depends on als_pkg.
module als_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_kind,
    input  logic               i_out_ready,
    input  als_pkg::t_status   i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output als_pkg::t_cmd      o_cmd
);
    import als_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV_GO  = 3'd1;
    localparam logic [2:0] S_DIV_RUN = 3'd2;
    localparam logic [2:0] S_PIX0    = 3'd3;
    localparam logic [2:0] S_PIX1    = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SEL_BITS-1:0] r_sel, n_sel;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_sel      = DIV_MINOR;
                        n_state    = S_DIV_GO;
                    end else if (i_status.line_active) begin
                        n_state = S_PIX0;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_sel = r_sel + 1'b1;
                    n_state = (r_sel == DIV_BLUE) ? S_IDLE : S_DIV_GO;
                end
            end
            S_PIX0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_PIX1;
                end
            end
            S_PIX1: begin
                o_out_valid   = 1'b1;
                o_cmd.pix_sel = 1'b1;
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DIV_MINOR;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

// ===== hw/rtl/antialiased_line_stepper.sv =====
// Top level of the anti-aliased line stepper: controller plus datapath.
// Depends on als_pkg, als_ctrl, als_datapath and als_div.

// A load request (tuser = 0) takes two endpoints with colours and emits
// nothing. Its setup runs four divisions on one shared restoring divider.
// Each division issues a start, develops 28 quotient bits and signals done.
// The block accepts no request until all four divisions are done.
// A step request (tuser = 1) on an active line yields a pair of pixels, one
// per cycle on the output stream while the sink is ready, with the upper
// minor pixel first. The next request can be taken the cycle after the second
// pixel is taken. A step with no active line is accepted and dropped.
module antialiased_line_stepper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_start, y_start, x_end, y_end, red/green/blue_start, red/green/blue_end
    input  logic [als_pkg::IN_BITS-1:0]   s_axis_tdata,
    // opcode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, coverage, zero pad
    output logic [als_pkg::OUT_BITS-1:0]  m_axis_tdata,
    // pair_last
    output logic                          m_axis_tlast,
    // line_done
    output logic                          m_axis_tuser
);
    import als_pkg::*;

    t_cmd    cmd;
    t_status status;

    als_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    als_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_data   (s_axis_tdata),
        .o_status (status),
        .o_data   (m_axis_tdata)
    );

    assign m_axis_tlast = cmd.pix_sel;
    assign m_axis_tuser = status.last_step;

    // Input and output sides never handshake in the same cycle.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");

    // The first pixel of a pair is always followed by its partner.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tlast))
        else $error("pixel pair broken");

    // The request side reopens once a pair has been taken.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("request side stuck after pair");

endmodule

// ===== tb/als_pixel_checker.sv =====
// Pixel stream checker for the anti-aliased line stepper: watches both
// streams, predicts every pixel pair and compares. Depends on als_pkg.
`timescale 1ns / 100ps

module als_pixel_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [als_pkg::IN_BITS-1:0]  i_req_data,
    input  logic                         i_req_user,
    input  logic                         i_pix_valid,
    input  logic                         i_pix_ready,
    input  logic [als_pkg::OUT_BITS-1:0] i_pix_data,
    input  logic                         i_pix_last,
    input  logic                         i_pix_user,
    output int                           o_fail_count,
    output int                           o_pending
);
    import als_pkg::*;

    typedef struct packed {
        logic [12:0] px;
        logic [12:0] py;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  cov;
        logic        last;
        logic        done;
    } t_pixel;

    t_pixel expected_pixels[$];

    // Predictor state of the line in progress.
    bit              active;
    bit              steep;
    bit              descending;
    logic [11:0]     major_pos;
    logic [11:0]     major_end;
    longint          minor_fx;
    longint          minor_inc;
    longint          colour_acc[3];
    longint          colour_inc[3];

    assign o_pending = expected_pixels.size();

    function automatic longint scaled_quotient(longint num, longint den);
        longint mag;
        if (den == 0) return 0;
        mag = num < 0 ? -num : num;
        mag = (mag << FRAC_BITS) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic logic [7:0] channel_level(longint acc);
        longint v;
        if (acc < 0) return 8'd0;
        v = acc >>> FRAC_BITS;
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    task automatic load_line(logic [IN_BITS-1:0] d);
        longint xs, ys, xe, ye, dx, dy, ady, span, t;
        longint cs[3], ce[3];
        xs = longint'(d[11:0]); ys = longint'(d[23:12]);
        xe = longint'(d[35:24]); ye = longint'(d[47:36]);
        for (int k = 0; k < 3; k++) begin
            cs[k] = longint'(d[48 + 8 * k +: 8]);
            ce[k] = longint'(d[72 + 8 * k +: 8]);
        end
        // Order endpoints so that x does not decrease.
        if (xe < xs) begin
            t = xs; xs = xe; xe = t;
            t = ys; ys = ye; ye = t;
            for (int k = 0; k < 3; k++) begin
                t = cs[k]; cs[k] = ce[k]; ce[k] = t;
            end
        end
        dx = xe - xs;
        dy = ye - ys;
        ady = dy < 0 ? -dy : dy;
        steep = (dx == 0) || (ady >= dx);
        if (steep) begin
            descending = dy < 0;
            major_pos = ys[11:0];
            major_end = ye[11:0];
            minor_fx = xs << FRAC_BITS;
            minor_inc = scaled_quotient(dx, ady);
            span = ady;
        end else begin
            descending = 0;
            major_pos = xs[11:0];
            major_end = xe[11:0];
            minor_fx = ys << FRAC_BITS;
            minor_inc = scaled_quotient(dy, dx);
            span = dx;
        end
        for (int k = 0; k < 3; k++) begin
            colour_acc[k] = cs[k] << FRAC_BITS;
            colour_inc[k] = scaled_quotient(ce[k] - cs[k], span);
        end
        active = 1;
    endtask

    task automatic step_line();
        longint frac, fl, cov;
        logic [12:0] lo, hi, maj;
        t_pixel p;
        bit done;
        frac = minor_fx & ((64'd1 << FRAC_BITS) - 1);
        fl = (minor_fx - frac) >>> FRAC_BITS;
        lo = fl[12:0];
        hi = fl[12:0] + 13'd1;
        maj = {1'b0, major_pos};
        cov = (frac * 255) >> FRAC_BITS;
        done = major_pos == major_end;
        for (int k = 0; k < 2; k++) begin
            p.px = steep ? (k == 0 ? hi : lo) : maj;
            p.py = steep ? maj : (k == 0 ? hi : lo);
            p.red = channel_level(colour_acc[0]);
            p.green = channel_level(colour_acc[1]);
            p.blue = channel_level(colour_acc[2]);
            p.cov = k == 0 ? cov[7:0] : 8'd255 - cov[7:0];
            p.last = (k == 1);
            p.done = done;
            expected_pixels.push_back(p);
        end
        if (done) begin
            active = 0;
        end else begin
            major_pos = descending ? major_pos - 12'd1 : major_pos + 12'd1;
            minor_fx += minor_inc;
            for (int k = 0; k < 3; k++) colour_acc[k] += colour_inc[k];
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    // Requests update the prediction; pixels are compared against it.
    always @(posedge i_clk) begin
        t_pixel w;
        if (!i_rst_n) begin
            active = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                if (i_req_user == OP_LOAD) load_line(i_req_data);
                else if (active) step_line();
            end
            if (i_pix_valid && i_pix_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel", 1, 0);
                end else begin
                    w = expected_pixels.pop_front();
                    if (i_pix_data[12:0] != w.px)
                        report_mismatch("pixel_x", longint'(i_pix_data[12:0]),
                                        longint'(w.px));
                    if (i_pix_data[25:13] != w.py)
                        report_mismatch("pixel_y", longint'(i_pix_data[25:13]),
                                        longint'(w.py));
                    if (i_pix_data[33:26] != w.red)
                        report_mismatch("red", longint'(i_pix_data[33:26]),
                                        longint'(w.red));
                    if (i_pix_data[41:34] != w.green)
                        report_mismatch("green", longint'(i_pix_data[41:34]),
                                        longint'(w.green));
                    if (i_pix_data[49:42] != w.blue)
                        report_mismatch("blue", longint'(i_pix_data[49:42]),
                                        longint'(w.blue));
                    if (i_pix_data[57:50] != w.cov)
                        report_mismatch("coverage", longint'(i_pix_data[57:50]),
                                        longint'(w.cov));
                    if (i_pix_data[63:58] != 6'd0)
                        report_mismatch("padding", longint'(i_pix_data[63:58]), 0);
                    if (i_pix_last != w.last)
                        report_mismatch("pair_last", longint'(i_pix_last),
                                        longint'(w.last));
                    if (i_pix_user != w.done)
                        report_mismatch("line_done", longint'(i_pix_user),
                                        longint'(w.done));
                end
            end
        end
    end
endmodule

// ===== tb/tb_antialiased_line_stepper.sv =====
// Top of the anti-aliased line stepper testbench: clock, reset, request
// stimulus and verdict. Depends on als_pkg, the block and als_pixel_checker.
`timescale 1ns / 100ps

module tb_antialiased_line_stepper;
    import als_pkg::*;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                s_axis_tvalid = 0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = 0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;
    int                  fail_count;
    int                  pending_pixels;
    bit                  calm_phase = 0;

    antialiased_line_stepper uut (.*);

    als_pixel_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_pix_valid(m_axis_tvalid), .i_pix_ready(m_axis_tready),
        .i_pix_data(m_axis_tdata), .i_pix_last(m_axis_tlast), .i_pix_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending_pixels));

    always #1 i_clk = ~i_clk;

    // Sink stalls at random, except during the calm stretch.
    always @(posedge i_clk) m_axis_tready <= calm_phase || ($urandom_range(99) >= 22);

    // Drives one request and holds it until it is taken. The valid line is
    // left high afterwards; the next request or an idle cycle replaces it.
    task automatic send_request(logic op, logic [IN_BITS-1:0] d);
        while (!calm_phase && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [IN_BITS-1:0] pack_line(
        int xs, int ys, int xe, int ye, logic [23:0] cs, logic [23:0] ce);
        return {ce, cs, ye[11:0], xe[11:0], ys[11:0], xs[11:0]};
    endfunction

    // Loads a line and walks it, with an optional cut-short step count.
    task automatic draw_line(logic [IN_BITS-1:0] d, int steps);
        send_request(OP_LOAD, d);
        for (int i = 0; i < steps; i++) send_request(OP_STEP, IN_BITS'($urandom));
    endtask

    int len;
    int xs, ys;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Step with no active line.
        send_request(OP_STEP, '1);
        // Single point, shallow, steep, vertical, descending steep, swapped x.
        draw_line(pack_line(4095, 4095, 4095, 4095, 24'hFFFFFF, 24'h000000), 2);
        draw_line(pack_line(0, 0, 5, 2, 24'h000000, 24'hFFFFFF), 6);
        draw_line(pack_line(10, 4095, 12, 4091, 24'hFF00FF, 24'h00FF00), 5);
        draw_line(pack_line(4095, 0, 4095, 3, 24'h123456, 24'hFEDCBA), 4);
        draw_line(pack_line(4095, 4095, 4093, 4090, 24'hFFFFFF, 24'h000000), 3);
        // Load replacing a line in progress.
        draw_line(pack_line(100, 200, 4000, 300, 24'h808080, 24'h7F7F7F), 2);
        draw_line(pack_line(4095, 4094, 4092, 4094, 24'h00FF00, 24'hFF00FF), 5);
        // Random lines, mostly short; a calm stretch in the middle.
        for (int n = 0; n < 65; n++) begin
            calm_phase = (n >= 25 && n < 37);
            xs = $urandom_range(4095);
            ys = $urandom_range(4095);
            len = $urandom_range(99) < 5 ? $urandom_range(40) : $urandom_range(5);
            draw_line(pack_line(xs, ys,
                      $urandom_range(99) < 10 ? $urandom_range(4095) :
                      (xs + $urandom_range(2 * len) - len) & 4095,
                      (ys + $urandom_range(2 * len) - len) & 4095,
                      24'($urandom), 24'($urandom)),
                      $urandom_range(8) == 0 ? 1 : 2 * len + 1);
        end
        s_axis_tvalid <= 0;
        calm_phase = 1;
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("antialiased_line_stepper verification clean");
        else
            $display("antialiased_line_stepper verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("antialiased_line_stepper verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/als_pkg.sv
hw/rtl/als_div.sv
hw/rtl/als_datapath.sv
hw/rtl/als_ctrl.sv
hw/rtl/antialiased_line_stepper.sv
tb/als_pixel_checker.sv
tb/tb_antialiased_line_stepper.sv
